// File: rtl/fit_policy_partition_allocator_assert.svh
// assertion helpers shared by the allocator rtl
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpa assertion failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpa assertion failed");

`endif

// File: rtl/fpa_pkg.sv
package fpa_pkg;

   localparam int FPA_PART_W     = 4;
   localparam int FPA_SIZE_W     = 16;
   localparam int FPA_MODE_W     = 2;
   localparam int FPA_PARTS_W    = 5;
   localparam int FPA_CSR_DATA_W = 5;
   localparam int FPA_CSR_IDX_W  = 1;

   localparam logic FPA_FUNC_LOAD  = 1'b0;
   localparam logic FPA_FUNC_ALLOC = 1'b1;

   localparam logic [FPA_MODE_W-1:0] FPA_MODE_FIRST = 2'd0;
   localparam logic [FPA_MODE_W-1:0] FPA_MODE_BEST  = 2'd1;
   localparam logic [FPA_MODE_W-1:0] FPA_MODE_WORST = 2'd2;

   localparam logic [FPA_CSR_IDX_W-1:0] FPA_CSR_FIT_MODE     = 1'd0;
   localparam logic [FPA_CSR_IDX_W-1:0] FPA_CSR_PARTS_IN_USE = 1'd1;

   typedef struct packed {
      logic                  func;
      logic [FPA_PART_W-1:0] part_index;
      logic [FPA_SIZE_W-1:0] req_size;
   } fpa_req_type;

   typedef struct packed {
      logic                  granted;
      logic [FPA_PART_W-1:0] chosen_part;
      logic [FPA_SIZE_W-1:0] space_left;
   } fpa_rsp_type;

   // search token control bits handed from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
   } fpa_tok_ctl_type;

   typedef enum logic [1:0] {
      FPA_IDLE,
      FPA_SEARCH,
      FPA_HOLD
   } fpa_state_type;

endpackage

// File: rtl/fit_policy_partition_allocator.sv
// Partition allocator with first, best and worst fit. A load transaction
// writes one partition's free size and returns nothing.
// A request transaction sends a search token down a chain of NUM_PARTS
// cells, one cell per cycle, each cell holding one partition's free size;
// at the chain's end the result is held in the HOLD state and is offered
// once the response register is free, and the next transaction is taken
// in that same cycle. Only partitions below parts_in_use take part in the
// search. Configuration is read live by the cells during a search.
module fit_policy_partition_allocator #(
   parameter int NUM_PARTS = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fpa_pkg::fpa_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fpa_pkg::fpa_rsp_type                  rsp_data,
   input  logic                                  csr_write_en,
   input  logic [fpa_pkg::FPA_CSR_IDX_W-1:0]     csr_index,
   input  logic [fpa_pkg::FPA_CSR_DATA_W-1:0]    csr_wdata
);
   import fpa_pkg::*;

   localparam int IDX_BITS  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int CNT_RAW   = $clog2(NUM_PARTS + 1);
   localparam int CNT_BITS  = (CNT_RAW > FPA_PARTS_W) ? CNT_RAW : FPA_PARTS_W;

   fpa_state_type              state_ff, state_in;
   logic [FPA_MODE_W-1:0]      fit_mode_ff;
   logic [FPA_PARTS_W-1:0]     parts_in_use_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   fpa_rsp_type                rsp_data_ff, rsp_data_in;
   fpa_rsp_type                hold_ff, hold_in;

   fpa_tok_ctl_type            tok_ctl  [0:NUM_PARTS];
   logic [IDX_BITS-1:0]        tok_idx  [0:NUM_PARTS];
   logic [SIZE_BITS-1:0]       tok_best [0:NUM_PARTS];
   logic [SIZE_BITS-1:0]       tok_need [0:NUM_PARTS];
   logic [NUM_PARTS-1:0]       chain_valid;

   logic                       req_fire;
   logic                       load_hit;
   logic                       tok_exit;
   logic [SIZE_BITS-1:0]       remaining;
   fpa_rsp_type                exit_rsp;
   logic                       wr_en;
   logic [IDX_BITS-1:0]        wr_idx;
   logic [SIZE_BITS-1:0]       wr_data;

   assign req_ready = (state_ff == FPA_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_hit  = req_fire && (req_data.func == FPA_FUNC_LOAD) &&
                      (int'(req_data.part_index) < NUM_PARTS);

   // token enters the head of the chain on an allocation request
   assign tok_ctl[0].valid = req_fire && (req_data.func == FPA_FUNC_ALLOC);
   assign tok_ctl[0].found = 1'b0;
   assign tok_idx[0]       = '0;
   assign tok_best[0]      = '0;
   assign tok_need[0]      = SIZE_BITS'(req_data.req_size);

   for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
      logic cell_active;
      assign cell_active    = CNT_BITS'(i) < CNT_BITS'(parts_in_use_ff);
      assign chain_valid[i] = tok_ctl[i+1].valid;

      fpa_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_BITS  (IDX_BITS),
         .CELL_IDX  (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .fit_mode     (fit_mode_ff),
         .active       (cell_active),
         .wr_en        (wr_en),
         .wr_idx       (wr_idx),
         .wr_data      (wr_data),
         .tok_ctl_in   (tok_ctl[i]),
         .tok_idx_in   (tok_idx[i]),
         .tok_best_in  (tok_best[i]),
         .tok_need_in  (tok_need[i]),
         .tok_ctl_out  (tok_ctl[i+1]),
         .tok_idx_out  (tok_idx[i+1]),
         .tok_best_out (tok_best[i+1]),
         .tok_need_out (tok_need[i+1])
      );
   end

   assign tok_exit  = tok_ctl[NUM_PARTS].valid;
   assign remaining = tok_best[NUM_PARTS] - tok_need[NUM_PARTS];

   always_comb begin
      exit_rsp = '0;
      if (tok_ctl[NUM_PARTS].found) begin
         exit_rsp.granted     = 1'b1;
         exit_rsp.chosen_part = FPA_PART_W'(tok_idx[NUM_PARTS]);
         exit_rsp.space_left  = FPA_SIZE_W'(remaining);
      end
   end

   // loads only happen in idle, commits only at token exit
   always_comb begin
      if (tok_exit) begin
         wr_en   = tok_ctl[NUM_PARTS].found;
         wr_idx  = tok_idx[NUM_PARTS];
         wr_data = remaining;
      end else begin
         wr_en   = load_hit;
         wr_idx  = IDX_BITS'(req_data.part_index);
         wr_data = SIZE_BITS'(req_data.req_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff     <= FPA_MODE_FIRST;
         parts_in_use_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            FPA_CSR_FIT_MODE:     fit_mode_ff     <= csr_wdata[FPA_MODE_W-1:0];
            FPA_CSR_PARTS_IN_USE: parts_in_use_ff <= csr_wdata[FPA_PARTS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FPA_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
   end

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         FPA_IDLE: begin
            if (tok_ctl[0].valid) begin
               state_in = FPA_SEARCH;
            end
         end
         FPA_SEARCH: begin
            if (tok_exit) begin
               hold_in  = exit_rsp;
               state_in = FPA_HOLD;
            end
         end
         FPA_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = FPA_IDLE;
            end
         end
         default: state_in = FPA_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "fit_policy_partition_allocator_assert.svh"

   // exactly one token in flight while searching, none otherwise
   `FPA_ASSERT_NOW(a_one_token, clock, reset, state_ff == FPA_SEARCH,
      $onehot(chain_valid))
   `FPA_ASSERT_NOW(a_no_token, clock, reset, state_ff != FPA_SEARCH, chain_valid == '0)
   `FPA_ASSERT_NEXT(a_alloc_starts, clock, reset, tok_ctl[0].valid, state_ff == FPA_SEARCH)
   `FPA_ASSERT_NOW(a_wait_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.granted,
      rsp_data_ff.chosen_part == '0 && rsp_data_ff.space_left == '0)

endmodule

// File: rtl/fpa_cell.sv
module fpa_cell #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_BITS  = 4,
   parameter int CELL_IDX  = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fpa_pkg::FPA_MODE_W-1:0]  fit_mode,
   input  logic                            active,
   input  logic                            wr_en,
   input  logic [IDX_BITS-1:0]             wr_idx,
   input  logic [SIZE_BITS-1:0]            wr_data,
   input  fpa_pkg::fpa_tok_ctl_type        tok_ctl_in,
   input  logic [IDX_BITS-1:0]             tok_idx_in,
   input  logic [SIZE_BITS-1:0]            tok_best_in,
   input  logic [SIZE_BITS-1:0]            tok_need_in,
   output fpa_pkg::fpa_tok_ctl_type        tok_ctl_out,
   output logic [IDX_BITS-1:0]             tok_idx_out,
   output logic [SIZE_BITS-1:0]            tok_best_out,
   output logic [SIZE_BITS-1:0]            tok_need_out
);
   import fpa_pkg::*;

   logic [SIZE_BITS-1:0] free_size_ff;
   fpa_tok_ctl_type      tok_ctl_ff, tok_ctl_in_q;
   logic [IDX_BITS-1:0]  tok_idx_ff, tok_idx_in_q;
   logic [SIZE_BITS-1:0] tok_best_ff, tok_best_in_q;
   logic [SIZE_BITS-1:0] tok_need_ff;
   logic                 fits;
   logic                 take;

   always_comb begin
      fits = tok_ctl_in.valid && active && (free_size_ff >= tok_need_in);
      take = 1'b0;
      if (fits) begin
         if (!tok_ctl_in.found) begin
            take = 1'b1;
         end else if (fit_mode == FPA_MODE_BEST) begin
            take = free_size_ff < tok_best_in;
         end else if (fit_mode == FPA_MODE_WORST) begin
            take = free_size_ff > tok_best_in;
         end
      end
      tok_ctl_in_q.valid = tok_ctl_in.valid;
      tok_ctl_in_q.found = tok_ctl_in.found || fits;
      tok_idx_in_q       = take ? IDX_BITS'(CELL_IDX) : tok_idx_in;
      tok_best_in_q      = take ? free_size_ff : tok_best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_size_ff <= '0;
         tok_ctl_ff   <= '0;
      end else begin
         if (wr_en && (wr_idx == IDX_BITS'(CELL_IDX))) begin
            free_size_ff <= wr_data;
         end
         tok_ctl_ff <= tok_ctl_in_q;
      end
   end

   always_ff @(posedge clock) begin
      tok_idx_ff  <= tok_idx_in_q;
      tok_best_ff <= tok_best_in_q;
      tok_need_ff <= tok_need_in;
   end

   assign tok_ctl_out  = tok_ctl_ff;
   assign tok_idx_out  = tok_idx_ff;
   assign tok_best_out = tok_best_ff;
   assign tok_need_out = tok_need_ff;

endmodule
